/* hdl/vlhe_pkg.sv */
// ----------------------------------------------------------------------------
// vlhe_pkg
// Shared widths, item type and parity helpers of the variable length
// Hamming encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package vlhe_pkg;

  // field widths
  localparam int MAX_DATA_BITS = 57;
  localparam int DATA_W        = 57;
  localparam int LEN_W         = 6;
  localparam int PAR_W         = 3;
  localparam int CW_W          = 63;
  localparam int PARITY_MAX    = 6;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // classified request: masked data plus code geometry
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  code_length;
    logic [PAR_W-1:0]  parity_count;
  } item_t;

  // positions covered by parity bit i (position p+1 sits at bit p)
  function automatic logic [CW_W-1:0] parity_mask(input int i);
    logic [CW_W-1:0] mask;
    int              pos;
    mask = '0;
    for (int p = 0; p < CW_W; p++) begin
      pos     = p + 1;
      mask[p] = pos[i];
    end
    return mask;
  endfunction

  // true when every parity group of the word holds an even count of ones
  function automatic logic syndrome_clear(input logic [CW_W-1:0] cw);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < PARITY_MAX; i++) begin
      if (^(cw & parity_mask(i))) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

/* hdl/vlhe_front.sv */
// ----------------------------------------------------------------------------
// vlhe_front
// Accepts requests, saturates the length, finds the parity count and code
// length, and masks unused data bits into a registered stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vlhe_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [vlhe_pkg::DATA_W-1:0]  data_bits,
  input  wire logic [vlhe_pkg::LEN_W-1:0]   data_length,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output vlhe_pkg::item_t                   out_item
);

  logic                        valid;
  vlhe_pkg::item_t             item;
  vlhe_pkg::item_t             cls;
  logic [vlhe_pkg::LEN_W-1:0]  m_sat;
  logic [vlhe_pkg::PAR_W-1:0]  r;

  // stage is blocked only while it holds a request the queue refuses
  assign full      = valid && !out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  // length saturation
  assign m_sat = (data_length > vlhe_pkg::LEN_W'(vlhe_pkg::MAX_DATA_BITS))
                 ? vlhe_pkg::LEN_W'(vlhe_pkg::MAX_DATA_BITS) : data_length;

  // least r with 2^r >= m + r + 1
  always_comb begin
    case (m_sat) inside
      6'd0:          r = 3'd0;
      6'd1:          r = 3'd2;
      [6'd2:6'd4]:   r = 3'd3;
      [6'd5:6'd11]:  r = 3'd4;
      [6'd12:6'd26]: r = 3'd5;
      default:       r = 3'd6;
    endcase
  end

  // classified request with stray data bits cleared
  always_comb begin
    for (int k = 0; k < vlhe_pkg::DATA_W; k++) begin
      cls.data[k] = data_bits[k] && (vlhe_pkg::LEN_W'(k) < m_sat);
    end
    cls.code_length  = m_sat + {{(vlhe_pkg::LEN_W-vlhe_pkg::PAR_W){1'b0}}, r};
    cls.parity_count = r;
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!full) begin
      valid <= push;
    end
    if (push && !full) begin
      item <= cls;
    end
  end

endmodule

`default_nettype wire

/* hdl/vlhe_queue.sv */
// ----------------------------------------------------------------------------
// vlhe_queue
// Short queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module vlhe_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire vlhe_pkg::item_t in_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output vlhe_pkg::item_t      out_item
);

  vlhe_pkg::item_t              mem [vlhe_pkg::QUEUE_DEPTH];
  logic [vlhe_pkg::QPTR_W-1:0]  wr_ptr;
  logic [vlhe_pkg::QPTR_W-1:0]  rd_ptr;
  logic [vlhe_pkg::QCNT_W-1:0]  count;
  logic                         wr_en;
  logic                         rd_en;

  assign in_ready  = count != vlhe_pkg::QCNT_W'(vlhe_pkg::QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_item  = mem[rd_ptr];
  assign wr_en     = in_valid && in_ready;
  assign rd_en     = out_valid && out_ready;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= in_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == vlhe_pkg::QPTR_W'(vlhe_pkg::QUEUE_DEPTH - 1))
                  ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == vlhe_pkg::QPTR_W'(vlhe_pkg::QUEUE_DEPTH - 1))
                  ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/vlhe_back.sv */
// ----------------------------------------------------------------------------
// vlhe_back
// Scatters data bits into the codeword, adds the parity bits and holds the
// result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vlhe_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire vlhe_pkg::item_t             in_item,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [vlhe_pkg::CW_W-1:0]        codeword,
  output logic [vlhe_pkg::LEN_W-1:0]       code_length,
  output logic [vlhe_pkg::PAR_W-1:0]       parity_count
);

  logic                        valid;
  logic [vlhe_pkg::CW_W-1:0]   cw;
  logic [vlhe_pkg::LEN_W-1:0]  di;

  assign empty    = !valid;
  assign in_ready = !valid || pop;

  // data bits go to positions that are not powers of two, then parity
  always_comb begin
    di = '0;
    cw = '0;
    for (int p = 0; p < vlhe_pkg::CW_W; p++) begin
      if (((p + 1) & p) != 0) begin
        cw[p] = in_item.data[di];
        di    = di + 1'b1;
      end
    end
    for (int i = 0; i < vlhe_pkg::PARITY_MAX; i++) begin
      if (vlhe_pkg::PAR_W'(i) < in_item.parity_count) begin
        cw[(1 << i) - 1] = ^(cw & vlhe_pkg::parity_mask(i));
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      codeword     <= cw;
      code_length  <= in_item.code_length;
      parity_count <= in_item.parity_count;
    end
  end

endmodule

`default_nettype wire

/* hdl/variable_length_hamming_encoder.sv */
// ----------------------------------------------------------------------------
// variable_length_hamming_encoder
// Even parity Hamming encoder for data words of 0 to 57 bits.
// ----------------------------------------------------------------------------
// Input side is a queue write port: a request (data_bits, data_length) is
// taken at a rising edge with push high and full low. Lengths above 57 are
// treated as 57 and data bits at or above the length are ignored.
// Result side is a queue read port: while empty is low the oldest result
// (codeword, code_length, parity_count) is on the ports, and it is taken at
// a rising edge with pop high.
// A request passes a classify register, a two entry queue and the encoder
// output register, in that order, before its result is shown. One request
// per cycle is taken and one result per cycle delivered while pop keeps up
// with the results; the parity trees in the back stage are combinational.
// When pop stays low, results wait in place and up to four requests are
// held inside before full rises; it falls as soon as a result is taken.
// Reset empties every stage: empty is high and full is low after it.
// ----------------------------------------------------------------------------
`default_nettype none

module variable_length_hamming_encoder (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [vlhe_pkg::DATA_W-1:0] data_bits,
  input  wire logic [vlhe_pkg::LEN_W-1:0]  data_length,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [vlhe_pkg::CW_W-1:0]        codeword,
  output logic [vlhe_pkg::LEN_W-1:0]       code_length,
  output logic [vlhe_pkg::PAR_W-1:0]       parity_count
);

  logic            front_valid;
  logic            front_ready;
  vlhe_pkg::item_t front_item;
  logic            queue_valid;
  logic            queue_ready;
  vlhe_pkg::item_t queue_item;

  // classify
  vlhe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .data_bits   (data_bits),
    .data_length (data_length),
    .out_valid   (front_valid),
    .out_ready   (front_ready),
    .out_item    (front_item)
  );

  // decoupling queue
  vlhe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_item   (front_item),
    .out_valid (queue_valid),
    .out_ready (queue_ready),
    .out_item  (queue_item)
  );

  // encode
  vlhe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (queue_valid),
    .in_ready     (queue_ready),
    .in_item      (queue_item),
    .empty        (empty),
    .pop          (pop),
    .codeword     (codeword),
    .code_length  (code_length),
    .parity_count (parity_count)
  );

  // all stages are empty right after reset
  assert property (@(posedge clk) rst |=> empty && !full)
    else $error("stages not cleared by reset");

  // no codeword bit above the code length
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> (codeword >> code_length) == '0)
    else $error("codeword bits set above code length");

  // every shown codeword has a clear syndrome
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> vlhe_pkg::syndrome_clear(codeword))
    else $error("codeword parity check failed");

  // parity count covers the code length
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> (7'd1 << parity_count) >= ({1'b0, code_length} + 7'd1))
    else $error("parity count too small for code length");

endmodule

`default_nettype wire
